// ----- rtl/core/rlbs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the RGB LED breathing serializer.
// No dependencies; imported by every module of the block.
package rlbs_pkg;

    // Chain and timing constants.
    localparam int LED_COUNT    = 128;
    localparam int ONE_CODE     = 68;
    localparam int ZERO_CODE    = 34;
    localparam int RESET_LENGTH = 40;

    localparam int BITS_PER_SLOT = 24;
    localparam int QUEUE_DEPTH   = 4;

    localparam int SLOT_W  = 7;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 24;
    localparam int CODE_W  = 16;
    localparam int ADDR_W  = 3;
    localparam int BITCNT_W = 5;
    localparam int GAPCNT_W = 6;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic [IDX_W:0]      LED_COUNT_X   = (IDX_W + 1)'(LED_COUNT);
    localparam logic [CODE_W-1:0]   ONE_CODE_V    = CODE_W'(ONE_CODE);
    localparam logic [CODE_W-1:0]   ZERO_CODE_V   = CODE_W'(ZERO_CODE);
    localparam logic [BITCNT_W-1:0] LAST_BIT      = BITCNT_W'(BITS_PER_SLOT - 1);
    localparam logic [GAPCNT_W-1:0] LAST_GAP      = GAPCNT_W'(RESET_LENGTH - 1);
    localparam logic [QCNT_W-1:0]   QUEUE_DEPTH_V = QCNT_W'(QUEUE_DEPTH);

    // Register indexes on the configuration port.
    localparam logic [ADDR_W-1:0] REG_LIT_FIRST    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_LIT_LAST     = 3'd1;
    localparam logic [ADDR_W-1:0] REG_COLOR_PEAK   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_DARK_A_FIRST = 3'd3;
    localparam logic [ADDR_W-1:0] REG_DARK_A_LAST  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_DARK_B_FIRST = 3'd5;
    localparam logic [ADDR_W-1:0] REG_DARK_B_LAST  = 3'd6;

    // One classified slot waiting for the serializer.
    typedef struct packed {
        logic [COLOR_W-1:0] grb;
        logic               last;
    } slot_entry_t;

    // Divide a product of two 8-bit values by 255, exact for all such products.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ----- rtl/core/rlbs_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, range checks, brightness triangle and colour scaling.
// Depends on rlbs_pkg; feeds rlbs_queue.
module rlbs_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rlbs_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [rlbs_pkg::COLOR_W-1:0] cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rlbs_pkg::SLOT_W-1:0]  s_slot_index,
    input  logic                        s_frame_end,
    output logic                        q_push,
    output rlbs_pkg::slot_entry_t       q_push_data,
    input  logic                        q_ready
);
    import rlbs_pkg::*;

    logic [IDX_W-1:0]   lit_first_reg, lit_last_reg;
    logic [IDX_W-1:0]   dark_a_first_reg, dark_a_last_reg;
    logic [IDX_W-1:0]   dark_b_first_reg, dark_b_last_reg;
    logic [COLOR_W-1:0] color_peak_reg;
    logic [7:0]         brightness_reg;
    logic               rising_reg;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [15:0]        g_prod_reg, r_prod_reg, b_prod_reg;

    logic               ranges_ok, lit, accept;
    logic [IDX_W-1:0]   idx;

    function automatic logic range_ok(input logic [IDX_W-1:0] first,
                                      input logic [IDX_W-1:0] last);
        return ({1'b0, first} < LED_COUNT_X) && ({1'b0, last} < LED_COUNT_X) &&
               (first <= last);
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] i,
                                      input logic [IDX_W-1:0] first,
                                      input logic [IDX_W-1:0] last);
        return (i >= first) && (i <= last);
    endfunction

    assign idx       = IDX_W'(s_slot_index);
    assign ranges_ok = range_ok(lit_first_reg, lit_last_reg) &&
                       range_ok(dark_a_first_reg, dark_a_last_reg) &&
                       range_ok(dark_b_first_reg, dark_b_last_reg);
    assign lit       = in_range(idx, lit_first_reg, lit_last_reg) &&
                       !in_range(idx, dark_a_first_reg, dark_a_last_reg) &&
                       !in_range(idx, dark_b_first_reg, dark_b_last_reg);

    assign s_ready = !s1_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign q_push  = s1_valid_reg && q_ready;

    assign q_push_data.grb  = {div255(g_prod_reg), div255(r_prod_reg), div255(b_prod_reg)};
    assign q_push_data.last = s1_last_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_first_reg    <= '0;
            lit_last_reg     <= '0;
            color_peak_reg   <= '0;
            dark_a_first_reg <= '0;
            dark_a_last_reg  <= '0;
            dark_b_first_reg <= '0;
            dark_b_last_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_LIT_FIRST:    lit_first_reg    <= cfg_wdata[IDX_W-1:0];
                REG_LIT_LAST:     lit_last_reg     <= cfg_wdata[IDX_W-1:0];
                REG_COLOR_PEAK:   color_peak_reg   <= cfg_wdata;
                REG_DARK_A_FIRST: dark_a_first_reg <= cfg_wdata[IDX_W-1:0];
                REG_DARK_A_LAST:  dark_a_last_reg  <= cfg_wdata[IDX_W-1:0];
                REG_DARK_B_FIRST: dark_b_first_reg <= cfg_wdata[IDX_W-1:0];
                REG_DARK_B_LAST:  dark_b_last_reg  <= cfg_wdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Brightness steps when a frame-ending slot is taken with valid ranges.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= '0;
            rising_reg     <= 1'b1;
        end else if (accept && ranges_ok && s_frame_end) begin
            if (rising_reg) begin
                brightness_reg <= brightness_reg + 8'd1;
                if (brightness_reg == 8'd254) begin
                    rising_reg <= 1'b0;
                end
            end else begin
                brightness_reg <= brightness_reg - 8'd1;
                if (brightness_reg == 8'd1) begin
                    rising_reg <= 1'b1;
                end
            end
        end
    end

    // Stage one: the slot is classified and its colour products formed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= ranges_ok;
        end else if (q_push) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_last_reg <= s_frame_end;
            g_prod_reg  <= lit ? 16'(color_peak_reg[23:16]) * 16'(brightness_reg) : '0;
            r_prod_reg  <= lit ? 16'(color_peak_reg[15:8]) * 16'(brightness_reg) : '0;
            b_prod_reg  <= lit ? 16'(color_peak_reg[7:0]) * 16'(brightness_reg) : '0;
        end
    end

endmodule

// ----- rtl/core/rlbs_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO of classified slots between the front end and the serializer.
// Depends on rlbs_pkg.
module rlbs_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rlbs_pkg::slot_entry_t push_data,
    output logic                  push_ready,
    input  logic                  pop,
    output rlbs_pkg::slot_entry_t head,
    output logic                  head_valid
);
    import rlbs_pkg::*;

    slot_entry_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign push_ready = (count_reg != QUEUE_DEPTH_V);
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/rlbs_back.sv -----
`timescale 1ns / 1ps
// Back end: serializes each slot into 24 codes and appends the reset gap after a frame.
// Depends on rlbs_pkg; drains rlbs_queue.
module rlbs_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rlbs_pkg::slot_entry_t       q_head,
    input  logic                        q_valid,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rlbs_pkg::CODE_W-1:0] m_pulse_width,
    output logic                        m_is_reset,
    output logic                        m_run_last
);
    import rlbs_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [COLOR_W-1:0]  shift_reg, shift_next;
    logic                last_reg, last_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [GAPCNT_W-1:0] gap_cnt_reg, gap_cnt_next;

    logic                m_valid_reg;
    logic [CODE_W-1:0]   pw_reg, pw_next;
    logic                is_reset_reg, is_reset_next;
    logic                run_last_reg, run_last_next;

    logic                out_free, have_work, take;
    logic [COLOR_W-1:0]  cur_grb;
    logic                cur_last;
    logic [BITCNT_W-1:0] cur_cnt;

    assign out_free  = !m_valid_reg || m_ready;
    assign have_work = (state_reg != PH_IDLE) || q_valid;
    assign take      = have_work && out_free;
    assign q_pop     = take && (state_reg == PH_IDLE);

    // From idle the queue head is serialized directly, so its first bit goes out at once.
    assign cur_grb  = (state_reg == PH_IDLE) ? q_head.grb  : shift_reg;
    assign cur_last = (state_reg == PH_IDLE) ? q_head.last : last_reg;
    assign cur_cnt  = (state_reg == PH_IDLE) ? '0 : bit_cnt_reg;

    always_comb begin
        state_next    = state_reg;
        shift_next    = shift_reg;
        last_next     = last_reg;
        bit_cnt_next  = bit_cnt_reg;
        gap_cnt_next  = gap_cnt_reg;
        pw_next       = pw_reg;
        is_reset_next = is_reset_reg;
        run_last_next = run_last_reg;
        if (take) begin
            unique case (state_reg) inside
                PH_IDLE, PH_DATA: begin
                    pw_next       = cur_grb[COLOR_W-1] ? ONE_CODE_V : ZERO_CODE_V;
                    is_reset_next = 1'b0;
                    run_last_next = (cur_cnt == LAST_BIT) && !cur_last;
                    shift_next    = {cur_grb[COLOR_W-2:0], 1'b0};
                    last_next     = cur_last;
                    bit_cnt_next  = cur_cnt + 1'b1;
                    if (cur_cnt == LAST_BIT) begin
                        gap_cnt_next = '0;
                        state_next   = cur_last ? PH_GAP : PH_IDLE;
                    end else begin
                        state_next = PH_DATA;
                    end
                end
                PH_GAP: begin
                    pw_next       = '0;
                    is_reset_next = 1'b1;
                    run_last_next = (gap_cnt_reg == LAST_GAP);
                    gap_cnt_next  = gap_cnt_reg + 1'b1;
                    if (gap_cnt_reg == LAST_GAP) begin
                        state_next = PH_IDLE;
                    end
                end
                default: begin
                    state_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg    <= shift_next;
        last_reg     <= last_next;
        bit_cnt_reg  <= bit_cnt_next;
        gap_cnt_reg  <= gap_cnt_next;
        pw_reg       <= pw_next;
        is_reset_reg <= is_reset_next;
        run_last_reg <= run_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pulse_width = pw_reg;
    assign m_is_reset    = is_reset_reg;
    assign m_run_last    = run_last_reg;

`ifndef SYNTH
    a_gap_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && is_reset_reg |-> pw_reg == '0)
        else $error("reset gap beat carries a nonzero code");

    a_data_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !is_reset_reg |-> pw_reg == ONE_CODE_V || pw_reg == ZERO_CODE_V)
        else $error("data beat carries an unknown code");

    a_gap_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == PH_GAP |-> gap_cnt_reg <= LAST_GAP)
        else $error("reset gap counter ran past its length");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid && state_reg == PH_IDLE)
        else $error("queue popped while empty or while serializing");
`endif

endmodule

// ----- rtl/core/rgb_led_breathe_serializer.sv -----
`timescale 1ns / 1ps
// Path: the first code of a slot passes through the front end's stage-one registers,
// the queue and the serializer's output register before it is presented on the m_ side.
// Throughput: set by the serializer, which puts out one code per cycle while slots wait and m_ready allows:
// 24 codes per slot, plus RESET_LENGTH gap codes after a frame-ending slot.
// Slots taken while any range is invalid are dropped at the front end with no output.
// Reset (aresetn, synchronous, active low) clears the control and configuration registers, brightness to 0, rising.
module rgb_led_breathe_serializer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port.
    input  logic                        cfg_we,
    input  logic [rlbs_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [rlbs_pkg::COLOR_W-1:0] cfg_wdata,
    // Slot input channel.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rlbs_pkg::SLOT_W-1:0]  s_slot_index,
    input  logic                        s_frame_end,
    // Code output channel.
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rlbs_pkg::CODE_W-1:0] m_pulse_width,
    output logic                        m_is_reset,
    output logic                        m_run_last
);
    import rlbs_pkg::*;

    // Front to queue.
    logic        q_push;
    logic        q_push_ready;
    slot_entry_t q_push_data;

    // Queue to back end.
    slot_entry_t q_head;
    logic        q_head_valid;
    logic        q_pop;

    // The front end checks the ranges, decides whether the slot is lit, scales the
    // colour peak by the current brightness and steps the brightness on a frame end.
    rlbs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_slot_index(s_slot_index),
        .s_frame_end (s_frame_end),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_ready     (q_push_ready)
    );

    // The queue lets the front end keep taking beats while the serializer is busy
    // with a long frame-ending slot.
    rlbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .push_ready(q_push_ready),
        .pop       (q_pop),
        .head      (q_head),
        .head_valid(q_head_valid)
    );

    // The back end sends green, red, blue, most significant bit first, then the
    // reset gap after a frame end, through a registered output stage.
    rlbs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_head       (q_head),
        .q_valid      (q_head_valid),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pulse_width(m_pulse_width),
        .m_is_reset   (m_is_reset),
        .m_run_last   (m_run_last)
    );

endmodule

// ----- dv/tb_rgb_led_breathe_serializer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rgb_led_breathe_serializer: directed and random slot traffic.
// Depends on rlbs_pkg for port widths and register indexes, and on the serializer RTL.
module tb_rgb_led_breathe_serializer;
    import rlbs_pkg::*;

    // Timing codes and chain length as the LED protocol defines them. They are kept
    // apart from the package so that the expected codes do not lean on the RTL.
    localparam logic [CODE_W-1:0] MARK_CODE  = 16'd68;
    localparam logic [CODE_W-1:0] SPACE_CODE = 16'd34;
    localparam int                GAP_CODES  = 40;
    localparam int                SLOT_BITS  = 24;
    localparam int                CHAIN_LEN  = 128;
    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [ADDR_W-1:0] REG_SPARE  = 3'd7;
    // Cycles allowed after the last expected code before the block counts as idle.
    // A slot dropped under invalid ranges leaves no code behind, so this margin
    // is what lets the scoreboard catch a stray code from such a slot.
    localparam int                SETTLE     = 8;

    // One expected code on the result channel.
    typedef struct packed {
        logic [CODE_W-1:0] pulse;
        logic              in_gap;
        logic              tail;
    } code_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [ADDR_W-1:0]    cfg_addr = '0;
    logic [COLOR_W-1:0]   cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [SLOT_W-1:0]    s_slot_index = '0;
    logic                 s_frame_end = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CODE_W-1:0]    m_pulse_width;
    logic                 m_is_reset;
    logic                 m_run_last;

    // Mirror of the block's registers and breathing state, as they stand after reset.
    logic [7:0]           lit_lo = '0;
    logic [7:0]           lit_hi = '0;
    logic [COLOR_W-1:0]   peak = '0;
    logic [7:0]           dark_a_lo = '0;
    logic [7:0]           dark_a_hi = '0;
    logic [7:0]           dark_b_lo = '0;
    logic [7:0]           dark_b_hi = '0;
    logic [7:0]           level = '0;
    bit                   climbing = 1'b1;

    code_t                pending_codes[$];
    int                   errors = 0;
    int                   codes_seen = 0;
    // When set, neither side idles at random; used for pressure tests and the closing sweep.
    bit                   quiet = 1'b0;
    // A request for the receiver to hold off for this many cycles.
    int                   hold_cycles = 0;

    rgb_led_breathe_serializer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_slot_index  (s_slot_index),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pulse_width (m_pulse_width),
        .m_is_reset    (m_is_reset),
        .m_run_last    (m_run_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Expected behavior
    // ------------------------------------------------------------------

    function automatic bit span_ok(input logic [7:0] lo, input logic [7:0] hi);
        return lo < CHAIN_LEN && hi < CHAIN_LEN && lo <= hi;
    endfunction

    function automatic bit ranges_valid();
        return span_ok(lit_lo, lit_hi) && span_ok(dark_a_lo, dark_a_hi) &&
               span_ok(dark_b_lo, dark_b_hi);
    endfunction

    function automatic bit covers(input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [SLOT_W-1:0] idx);
        return {1'b0, idx} >= lo && {1'b0, idx} <= hi;
    endfunction

    // Scale one colour channel by the current brightness, truncating.
    function automatic logic [7:0] dim(input logic [7:0] full, input logic [7:0] lvl);
        int unsigned prod;
        prod = int'(full) * int'(lvl);
        return 8'(prod / 255);
    endfunction

    // Queue the codes that one accepted slot must produce, then step the breathing
    // triangle if the slot closes a frame. Nothing comes out of a slot taken while
    // any range is invalid, and the triangle does not move either.
    task automatic predict_slot_codes(input logic [SLOT_W-1:0] idx, input logic fin);
        logic [23:0] grb;
        code_t       c;
        int          total;
        int          k;
        if (!ranges_valid())
            return;
        grb = '0;
        // The forced-off ranges win over the lit range.
        if (covers(lit_lo, lit_hi, idx) && !covers(dark_a_lo, dark_a_hi, idx) &&
            !covers(dark_b_lo, dark_b_hi, idx))
            grb = {dim(peak[23:16], level), dim(peak[15:8], level), dim(peak[7:0], level)};
        total = fin ? SLOT_BITS + GAP_CODES : SLOT_BITS;
        for (k = 0; k < total; k++) begin
            // Green first, most significant bit first, then the reset gap.
            if (k < SLOT_BITS)
                c.pulse = grb[SLOT_BITS - 1 - k] ? MARK_CODE : SPACE_CODE;
            else
                c.pulse = '0;
            c.in_gap = (k >= SLOT_BITS);
            c.tail = (k == total - 1);
            pending_codes.push_back(c);
        end
        if (fin) begin
            if (climbing) begin
                level = level + 8'd1;
                if (level == 8'hFF)
                    climbing = 1'b0;
            end else begin
                level = level - 8'd1;
                if (level == 8'h00)
                    climbing = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t ns, code %0d: %s", $time, codes_seen, what);
    endtask

    // Both channels are sampled here, before the edge's updates land. A slot beat
    // is turned into expected codes first, so its codes are always queued in time:
    // the first of them must pass the stage-one registers, the queue and the output register.
    always @(posedge aclk) begin : scoreboard
        code_t want;
        if (aresetn && s_valid && s_ready === 1'b1)
            predict_slot_codes(s_slot_index, s_frame_end);
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_codes.size() == 0) begin
                report_mismatch($sformatf("unexpected code, pulse_width %0d", m_pulse_width));
            end else begin
                want = pending_codes.pop_front();
                if (m_pulse_width !== want.pulse)
                    report_mismatch($sformatf("pulse_width %0d, expected %0d",
                                              m_pulse_width, want.pulse));
                if (m_is_reset !== want.in_gap)
                    report_mismatch($sformatf("is_reset %0b, expected %0b",
                                              m_is_reset, want.in_gap));
                if (m_run_last !== want.tail)
                    report_mismatch($sformatf("run_last %0b, expected %0b",
                                              m_run_last, want.tail));
            end
            codes_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready with random stalls, or a long hold-off on request.
    // Each pass through the loop makes exactly one assignment to m_ready.
    // ------------------------------------------------------------------

    initial begin : result_sink
        int burst;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                burst = hold_cycles;
                hold_cycles = 0;
                m_ready <= 1'b0;
                repeat (burst - 1) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 3);
                m_ready <= 1'b0;
                repeat (burst - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers. All of them are entered just after a rising edge.
    // ------------------------------------------------------------------

    // Offer one slot and hold it until the beat; then maybe leave a short gap.
    // Without a gap valid simply stays high for the next slot.
    task automatic send_slot(input logic [SLOT_W-1:0] idx, input logic fin);
        int gap;
        s_valid <= 1'b1;
        s_slot_index <= idx;
        s_frame_end <= fin;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering slots, wait for every expected code, then let settle cycles pass.
    // The first edge lets the scoreboard turn the last slot beat into codes.
    task automatic wait_idle(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_codes.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // One register write; the enable stays high so that writes can run back to back.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [COLOR_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        // Bits above a register's width are dropped by the block.
        case (addr)
            REG_LIT_FIRST:    lit_lo = data[7:0];
            REG_LIT_LAST:     lit_hi = data[7:0];
            REG_COLOR_PEAK:   peak = data;
            REG_DARK_A_FIRST: dark_a_lo = data[7:0];
            REG_DARK_A_LAST:  dark_a_hi = data[7:0];
            REG_DARK_B_FIRST: dark_b_lo = data[7:0];
            REG_DARK_B_LAST:  dark_b_hi = data[7:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Write all seven registers, with random junk above the 8-bit fields.
    task automatic set_config(input logic [7:0] lf, input logic [7:0] ll,
                              input logic [COLOR_W-1:0] color,
                              input logic [7:0] af, input logic [7:0] al,
                              input logic [7:0] bf, input logic [7:0] bl);
        write_reg(REG_LIT_FIRST, {16'($urandom), lf});
        write_reg(REG_LIT_LAST, {16'($urandom), ll});
        write_reg(REG_COLOR_PEAK, color);
        write_reg(REG_DARK_A_FIRST, {16'($urandom), af});
        write_reg(REG_DARK_A_LAST, {16'($urandom), al});
        write_reg(REG_DARK_B_FIRST, {16'($urandom), bf});
        write_reg(REG_DARK_B_LAST, {16'($urandom), bl});
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset every range is [0, 0], so slot 0 is forced off and
    // nothing can light. A frame end must still step the brightness.
    task automatic test_reset_defaults;
        send_slot(7'd0, 1'b0);
        send_slot(7'd5, 1'b1);
        wait_idle(SETTLE);
    endtask

    // Wide data on the narrow registers and a write to the spare index.
    task automatic test_register_writes;
        write_reg(REG_LIT_FIRST, 24'hFF_FF_02);
        write_reg(REG_LIT_LAST, 24'h12_34_09);
        write_reg(REG_COLOR_PEAK, 24'hFF_80_01);
        write_reg(REG_DARK_A_FIRST, 24'hEE_00_04);
        write_reg(REG_DARK_A_LAST, 24'h00_01_04);
        write_reg(REG_DARK_B_FIRST, 24'hA5_5A_07);
        write_reg(REG_DARK_B_LAST, 24'h80_00_08);
        write_reg(REG_SPARE, 24'hFF_FF_FF);
        cfg_we <= 1'b0;
        send_slot(7'd1, 1'b0);
        send_slot(7'd2, 1'b0);
        send_slot(7'd4, 1'b0);
        send_slot(7'd5, 1'b0);
        send_slot(7'd7, 1'b0);
        send_slot(7'd9, 1'b0);
        send_slot(7'd10, 1'b1);
        wait_idle(SETTLE);
    endtask

    // Ranges at both ends of the chain, full and zero colour.
    task automatic test_range_extremes;
        set_config(8'd0, 8'd127, 24'hFF_FF_FF, 8'd0, 8'd0, 8'd127, 8'd127);
        send_slot(7'd0, 1'b0);
        send_slot(7'd1, 1'b0);
        send_slot(7'd126, 1'b0);
        send_slot(7'd127, 1'b1);
        wait_idle(SETTLE);
        set_config(8'd127, 8'd127, 24'hFF_FF_FF, 8'd0, 8'd0, 8'd0, 8'd0);
        send_slot(7'd127, 1'b0);
        send_slot(7'd126, 1'b1);
        wait_idle(SETTLE);
        set_config(8'd0, 8'd127, 24'h00_00_00, 8'd64, 8'd64, 8'd65, 8'd65);
        send_slot(7'd127, 1'b0);
        send_slot(7'd0, 1'b1);
        wait_idle(SETTLE);
    endtask

    // Each way a range can be broken: an end at or past the chain length, or a
    // first index above the last. Slots vanish and frame ends leave the
    // brightness alone, which the closing frame then shows.
    task automatic test_invalid_ranges;
        set_config(8'd0, 8'd128, 24'hFF_FF_FF, 8'd0, 8'd0, 8'd0, 8'd0);
        send_slot(7'd3, 1'b1);
        wait_idle(SETTLE);
        set_config(8'd128, 8'd255, 24'hFF_FF_FF, 8'd0, 8'd0, 8'd0, 8'd0);
        send_slot(7'd3, 1'b1);
        wait_idle(SETTLE);
        set_config(8'd9, 8'd8, 24'hFF_FF_FF, 8'd0, 8'd0, 8'd0, 8'd0);
        send_slot(7'd8, 1'b1);
        wait_idle(SETTLE);
        set_config(8'd0, 8'd127, 24'hFF_FF_FF, 8'd10, 8'd200, 8'd0, 8'd0);
        send_slot(7'd3, 1'b1);
        wait_idle(SETTLE);
        set_config(8'd0, 8'd127, 24'hFF_FF_FF, 8'd0, 8'd0, 8'd50, 8'd40);
        send_slot(7'd3, 1'b1);
        wait_idle(SETTLE);
        set_config(8'd0, 8'd127, 24'hFF_FF_FF, 8'd0, 8'd0, 8'd0, 8'd0);
        send_slot(7'd3, 1'b1);
        wait_idle(SETTLE);
    endtask

    // The receiver holds off for a long stretch while slots keep coming, so the
    // slot queue fills and the block must stall its input side.
    task automatic test_output_backpressure;
        int k;
        set_config(8'd0, 8'd127, 24'h5A_C3_81, 8'd40, 8'd40, 8'd90, 8'd92);
        quiet = 1'b1;
        hold_cycles = 300;
        for (k = 0; k < 10; k++)
            send_slot(7'(36 + k), k % 3 == 2);
        quiet = 1'b0;
        wait_idle(SETTLE);
    endtask

    // Pick a fresh register set for a random phase. Off ranges stay narrow so
    // that plenty of slots light; now and then one range is broken on purpose.
    task automatic pick_random_config(input int phase);
        logic [7:0]         lf;
        logic [7:0]         ll;
        logic [7:0]         af;
        logic [7:0]         al;
        logic [7:0]         bf;
        logic [7:0]         bl;
        logic [COLOR_W-1:0] color;
        if ($urandom_range(0, 1) == 0) begin
            lf = 8'd0;
            ll = 8'd127;
        end else begin
            lf = 8'($urandom_range(0, 127));
            ll = 8'($urandom_range(int'(lf), 127));
        end
        af = 8'($urandom_range(0, 127));
        al = 8'($urandom_range(int'(af), (af > 125) ? 127 : int'(af) + 2));
        bf = 8'($urandom_range(0, 127));
        bl = 8'($urandom_range(int'(bf), (bf > 125) ? 127 : int'(bf) + 2));
        case ($urandom_range(0, 5))
            0:       color = 24'h00_00_00;
            1:       color = 24'hFF_FF_FF;
            default: color = 24'($urandom);
        endcase
        if (phase == 0) begin
            // Whole chain lit at full colour, off ranges pinned to the two ends.
            lf = 8'd0;
            ll = 8'd127;
            af = 8'd0;
            al = 8'd0;
            bf = 8'd127;
            bl = 8'd127;
            color = 24'hFF_FF_FF;
        end else if (phase > 1 && $urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
                0:       ll = 8'($urandom_range(128, 255));
                1:       bf = bl + 8'd1;
                default: af = 8'($urandom_range(128, 255));
            endcase
        end
        set_config(lf, ll, color, af, al, bf, bl);
    endtask

    // Phases of random traffic, one register set each. Most traffic is runs of
    // consecutive slots closed by a frame end; the rest is lone slots with a
    // random mark. Now and then the sender stops until every code is out.
    task automatic test_random_traffic;
        int               phase;
        int               sent;
        int               target;
        int               len;
        int               k;
        logic [SLOT_W-1:0] first;
        for (phase = 0; phase < 6; phase++) begin
            pick_random_config(phase);
            // Under broken ranges the slots are only dropped, so keep those phases short.
            target = ranges_valid() ? 16 : 6;
            sent = 0;
            while (sent < target) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_slot(7'($urandom), 1'($urandom));
                    sent++;
                end else begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30)
                                                      : $urandom_range(1, 6);
                    first = 7'($urandom);
                    for (k = 0; k < len; k++)
                        send_slot(7'(first + k), k == len - 1);
                    sent += len;
                end
                if ($urandom_range(0, 11) == 0)
                    wait_idle(0);
            end
            wait_idle(SETTLE);
        end
    endtask

    // Single-slot frames with no idling on either side, enough of them to carry
    // the brightness over the top of the triangle and a few steps back down,
    // checking every scaled level on the way.
    task automatic test_breathing_sweep;
        int k;
        set_config(8'd0, 8'd3, 24'hFF_96_2D, 8'd127, 8'd127, 8'd126, 8'd126);
        quiet = 1'b1;
        k = 0;
        while (climbing || level > 8'd250) begin
            send_slot(7'(k % 4), 1'b1);
            k++;
        end
        wait_idle(SETTLE);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : regression
        // Reset is held low from time zero and released once for the whole run.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_register_writes();
        test_range_extremes();
        test_invalid_ranges();
        test_output_backpressure();
        test_random_traffic();
        test_breathing_sweep();
        if (pending_codes.size() != 0)
            report_mismatch($sformatf("%0d expected codes never came",
                                      pending_codes.size()));
        if (errors == 0)
            $display("rgb_led_breathe_serializer regression: pass");
        else
            $display("rgb_led_breathe_serializer regression: fail");
        $finish;
    end

    // A run that never drains ends here; the limit is far above the slowest
    // legal run, every code stalled and every frame carrying its reset gap.
    initial begin : watchdog
        #12_000_000;
        $display("rgb_led_breathe_serializer regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rlbs_pkg.sv
rtl/core/rlbs_front.sv
rtl/core/rlbs_queue.sv
rtl/core/rlbs_back.sv
rtl/core/rgb_led_breathe_serializer.sv
dv/tb_rgb_led_breathe_serializer.sv
